// ===== src/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// dll_pkg
// Operation and status codes and result field widths for the doubly linked
// list manager.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int NODE_W  = 8;
  localparam int COUNT_W = 9;

  typedef logic [2:0]         mode_t;
  typedef logic [1:0]         status_t;
  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam mode_t MODE_PUSH_BACK  = 3'd0;
  localparam mode_t MODE_PUSH_FRONT = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_REMOVE     = 3'd4;
  localparam mode_t MODE_INSPECT    = 3'd5;

  localparam status_t STATUS_DONE      = 2'd0;
  localparam status_t STATUS_EMPTY     = 2'd1;
  localparam status_t STATUS_MEMBERSHIP = 2'd2;

endpackage

// ===== src/dll_link_mem.sv =====
// ----------------------------------------------------------------------------
// dll_link_mem
// Link table: one write port and two read ports, read data registered and
// held until the next read enable.
// ----------------------------------------------------------------------------
module dll_link_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  output logic [DW-1:0] ra_data,
  output logic [DW-1:0] rb_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] ra_data_r;
  logic [DW-1:0] rb_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      ra_data_r <= mem_r[ra_addr];
      rb_data_r <= mem_r[rb_addr];
    end
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

// ===== src/doubly_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// One doubly linked list over a pool of node indices: push, pop, remove and
// inspect, one result per item.
// ----------------------------------------------------------------------------
// Each item passes through a read cycle on the prev and next link memories
// (at the victim node and at the input node), then a write-back cycle that
// patches the neighbours' links, updates head, tail, count and membership and
// loads the result register. A new item is taken in the write-back cycle, as
// the last one commits; a result that is not taken holds the write-back until
// the output register frees. Membership bits sit in flip-flops cleared by
// reset, so no clearing pass is needed; only node indices below 256 can ever
// join, which bounds the tables at 256 entries.
module doubly_linked_list_manager #(
  parameter int NODES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dll_pkg::mode_t    in_mode,
  input  dll_pkg::node_t    in_node,
  output logic              out_valid,
  input  logic              out_ready,
  output dll_pkg::status_t  out_status,
  output dll_pkg::node_t    out_popped_node,
  output logic              out_popped_valid,
  output dll_pkg::node_t    out_head_node,
  output logic              out_head_valid,
  output dll_pkg::node_t    out_tail_node,
  output logic              out_tail_valid,
  output dll_pkg::count_t   out_count,
  output dll_pkg::node_t    out_node_prev,
  output logic              out_node_prev_valid,
  output dll_pkg::node_t    out_node_next,
  output logic              out_node_next_valid
);

  import dll_pkg::*;

  localparam int MD = (NODES < 256) ? NODES : 256;
  localparam int IW = $clog2(MD);
  localparam int CW = $clog2(MD + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  mode_t         mode_r;
  node_t         node_r;
  logic [MD-1:0] member_r, member_nxt;
  logic          head_vld_r, head_vld_nxt;
  logic [IW-1:0] head_idx_r, head_idx_nxt;
  logic          tail_vld_r, tail_vld_nxt;
  logic [IW-1:0] tail_idx_r, tail_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          out_valid_r;
  status_t       status_r, status_nxt;
  node_t         popped_r, popped_nxt;
  logic          popped_vld_r, popped_vld_nxt;
  node_t         hnode_r, tnode_r;
  logic          hvld_r, tvld_r;
  count_t        ocount_r;
  node_t         nprev_r, nprev_nxt;
  logic          nprev_vld_r, nprev_vld_nxt;
  node_t         nnext_r, nnext_nxt;
  logic          nnext_vld_r, nnext_vld_nxt;

  logic          accept, commit;
  logic          is_push, is_pop, is_rem, at_back;
  logic          inrange, member, push_ok, vic_ok;
  logic [IW-1:0] node_idx, vic_idx;

  logic          pw_en, nw_en;
  logic [IW-1:0] pw_addr, nw_addr;
  logic [IW:0]   pw_data, nw_data;
  logic [IW:0]   new_prev, new_next;
  logic [IW:0]   vp, vq, xp, xn;
  logic          keep_member;

  assign commit   = (state_r == ST_WR) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    is_rem  = 1'b0;
    at_back = 1'b0;
    unique case (mode_r) inside
      MODE_PUSH_BACK:  begin is_push = 1'b1; at_back = 1'b1; end
      MODE_PUSH_FRONT: is_push = 1'b1;
      MODE_POP_FRONT:  is_pop = 1'b1;
      MODE_POP_BACK:   begin is_pop = 1'b1; at_back = 1'b1; end
      MODE_REMOVE:     is_rem = 1'b1;
      default:         ;
    endcase
  end

  assign inrange  = 32'(node_r) < NODES;
  assign node_idx = IW'(node_r);
  assign member   = inrange && member_r[node_idx];
  assign push_ok  = is_push && inrange && !member;
  assign vic_ok   = (is_pop && head_vld_r) || (is_rem && member);

  always_comb begin
    if (is_pop) begin
      vic_idx = at_back ? tail_idx_r : head_idx_r;
    end else begin
      vic_idx = node_idx;
    end
  end

  // Links of a freshly pushed node
  always_comb begin
    new_prev = '0;
    new_next = '0;
    if (head_vld_r) begin
      if (at_back) begin
        new_prev = {1'b1, tail_idx_r};
      end else begin
        new_next = {1'b1, head_idx_r};
      end
    end
  end

  dll_link_mem #(.DEPTH(MD), .AW(IW), .DW(IW + 1)) u_prev_mem (
    .clk     (clk),
    .we      (pw_en),
    .waddr   (pw_addr),
    .wdata   (pw_data),
    .re      (state_r == ST_RD),
    .ra_addr (vic_idx),
    .rb_addr (node_idx),
    .ra_data (vp),
    .rb_data (xp)
  );

  dll_link_mem #(.DEPTH(MD), .AW(IW), .DW(IW + 1)) u_next_mem (
    .clk     (clk),
    .we      (nw_en),
    .waddr   (nw_addr),
    .wdata   (nw_data),
    .re      (state_r == ST_RD),
    .ra_addr (vic_idx),
    .rb_addr (node_idx),
    .ra_data (vq),
    .rb_data (xn)
  );

  // Pushed node's own links go in the read cycle, neighbour patches at commit
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = node_idx;
    pw_data = new_prev;
    nw_en   = 1'b0;
    nw_addr = node_idx;
    nw_data = new_next;
    if (state_r == ST_RD && push_ok) begin
      pw_en = 1'b1;
      nw_en = 1'b1;
    end else if (commit) begin
      if (push_ok && head_vld_r) begin
        if (at_back) begin
          nw_en   = 1'b1;
          nw_addr = tail_idx_r;
          nw_data = {1'b1, node_idx};
        end else begin
          pw_en   = 1'b1;
          pw_addr = head_idx_r;
          pw_data = {1'b1, node_idx};
        end
      end else if (vic_ok) begin
        if (vq[IW]) begin
          pw_en   = 1'b1;
          pw_addr = vq[IW-1:0];
          pw_data = vp;
        end
        if (vp[IW]) begin
          nw_en   = 1'b1;
          nw_addr = vp[IW-1:0];
          nw_data = vq;
        end
      end
    end
  end

  always_comb begin
    member_nxt     = member_r;
    head_vld_nxt   = head_vld_r;
    head_idx_nxt   = head_idx_r;
    tail_vld_nxt   = tail_vld_r;
    tail_idx_nxt   = tail_idx_r;
    count_nxt      = count_r;
    status_nxt     = STATUS_DONE;
    popped_nxt     = '0;
    popped_vld_nxt = 1'b0;
    if (push_ok) begin
      member_nxt[node_idx] = 1'b1;
      count_nxt = count_r + CW'(1);
      if (!head_vld_r || at_back) begin
        tail_vld_nxt = 1'b1;
        tail_idx_nxt = node_idx;
      end
      if (!head_vld_r || !at_back) begin
        head_vld_nxt = 1'b1;
        head_idx_nxt = node_idx;
      end
    end else if (vic_ok) begin
      member_nxt[vic_idx] = 1'b0;
      if (count_r != '0) begin
        count_nxt = count_r - CW'(1);
      end
      if (!vp[IW]) begin
        head_vld_nxt = vq[IW];
        head_idx_nxt = vq[IW-1:0];
      end
      if (!vq[IW]) begin
        tail_vld_nxt = vp[IW];
        tail_idx_nxt = vp[IW-1:0];
      end
      if (is_pop) begin
        popped_nxt     = NODE_W'(vic_idx);
        popped_vld_nxt = 1'b1;
      end
    end else if (is_pop) begin
      status_nxt = STATUS_EMPTY;
    end else if (is_push || is_rem) begin
      status_nxt = STATUS_MEMBERSHIP;
    end
  end

  // Input node's links after the step
  assign keep_member = member && !(vic_ok && node_idx == vic_idx);

  always_comb begin
    logic [IW:0] lp, ln;
    lp = '0;
    ln = '0;
    if (push_ok) begin
      lp = new_prev;
      ln = new_next;
    end else if (keep_member) begin
      lp = (vic_ok && vq[IW] && vq[IW-1:0] == node_idx) ? vp : xp;
      ln = (vic_ok && vp[IW] && vp[IW-1:0] == node_idx) ? vq : xn;
    end
    nprev_vld_nxt = lp[IW];
    nprev_nxt     = lp[IW] ? NODE_W'(lp[IW-1:0]) : '0;
    nnext_vld_nxt = ln[IW];
    nnext_nxt     = ln[IW] ? NODE_W'(ln[IW-1:0]) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR: begin
        if (commit) begin
          state_nxt = in_valid ? ST_RD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      member_r    <= '0;
      head_vld_r  <= 1'b0;
      head_idx_r  <= '0;
      tail_vld_r  <= 1'b0;
      tail_idx_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        member_r    <= member_nxt;
        head_vld_r  <= head_vld_nxt;
        head_idx_r  <= head_idx_nxt;
        tail_vld_r  <= tail_vld_nxt;
        tail_idx_r  <= tail_idx_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      node_r <= in_node;
    end
    if (commit) begin
      status_r     <= status_nxt;
      popped_r     <= popped_nxt;
      popped_vld_r <= popped_vld_nxt;
      hvld_r       <= head_vld_nxt;
      hnode_r      <= head_vld_nxt ? NODE_W'(head_idx_nxt) : '0;
      tvld_r       <= tail_vld_nxt;
      tnode_r      <= tail_vld_nxt ? NODE_W'(tail_idx_nxt) : '0;
      ocount_r     <= COUNT_W'(count_nxt);
      nprev_r      <= nprev_nxt;
      nprev_vld_r  <= nprev_vld_nxt;
      nnext_r      <= nnext_nxt;
      nnext_vld_r  <= nnext_vld_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_popped_node     = popped_r;
  assign out_popped_valid    = popped_vld_r;
  assign out_head_node       = hnode_r;
  assign out_head_valid      = hvld_r;
  assign out_tail_node       = tnode_r;
  assign out_tail_valid      = tvld_r;
  assign out_count           = ocount_r;
  assign out_node_prev       = nprev_r;
  assign out_node_prev_valid = nprev_vld_r;
  assign out_node_next       = nnext_r;
  assign out_node_next_valid = nnext_vld_r;

`ifndef NO_ASSERTIONS
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld_r == (count_r != '0))
    else $error("head valid disagrees with node count");

  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld_r == tail_vld_r)
    else $error("head and tail validity differ");

  a_members: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(member_r) == 32'(count_r))
    else $error("membership bits disagree with node count");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item produced no result");
`endif

endmodule

// ===== verif/dll_list_checker.sv =====
// ----------------------------------------------------------------------------
// dll_list_checker
// Watches both channels of the list manager. It keeps its own copy of the
// list (links, membership, head, tail, count), works out the result of every
// accepted item, and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module dll_list_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  dll_pkg::mode_t   in_mode,
  input  dll_pkg::node_t   in_node,
  input  logic             out_valid,
  input  logic             out_ready,
  input  dll_pkg::status_t out_status,
  input  dll_pkg::node_t   out_popped_node,
  input  logic             out_popped_valid,
  input  dll_pkg::node_t   out_head_node,
  input  logic             out_head_valid,
  input  dll_pkg::node_t   out_tail_node,
  input  logic             out_tail_valid,
  input  dll_pkg::count_t  out_count,
  input  dll_pkg::node_t   out_node_prev,
  input  logic             out_node_prev_valid,
  input  dll_pkg::node_t   out_node_next,
  input  logic             out_node_next_valid,
  output int unsigned      fail_count,
  output int unsigned      awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  import dll_pkg::*;

  localparam int POOL = 256;

  typedef struct packed {
    logic  ok;
    node_t idx;
  } link_t;

  typedef struct packed {
    status_t status;
    link_t   popped;
    link_t   head;
    link_t   tail;
    count_t  count;
    link_t   prev;
    link_t   next;
  } list_view_t;

  localparam link_t NO_LINK = '{ok: 1'b0, idx: '0};

  link_t       prev_tab [POOL];
  link_t       next_tab [POOL];
  logic        member   [POOL];
  link_t       head_q;
  link_t       tail_q;
  count_t      cnt;
  list_view_t  expected_q[$];
  int unsigned fails = 0;
  int unsigned results_seen = 0;

  initial begin
    fail_count = 0;
    awaited    = 0;
  end

  function automatic link_t to_link(node_t n);
    return '{ok: 1'b1, idx: n};
  endfunction

  // Unlink a member from wherever it sits.
  function automatic void detach(node_t n);
    link_t p;
    link_t q;
    p = prev_tab[n];
    q = next_tab[n];
    if (!p.ok) head_q = q;
    else next_tab[p.idx] = q;
    if (!q.ok) tail_q = p;
    else prev_tab[q.idx] = p;
    prev_tab[n] = NO_LINK;
    next_tab[n] = NO_LINK;
    member[n]   = 1'b0;
    if (cnt != '0) cnt = cnt - count_t'(1);
  endfunction

  function automatic list_view_t apply_item(mode_t m, node_t n);
    list_view_t v;
    link_t      victim;
    v        = '0;
    v.status = STATUS_DONE;
    v.popped = NO_LINK;
    case (m)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (member[n]) begin
          v.status = STATUS_MEMBERSHIP;
        end else begin
          member[n] = 1'b1;
          cnt = cnt + count_t'(1);
          if (!head_q.ok) begin
            prev_tab[n] = NO_LINK;
            next_tab[n] = NO_LINK;
            head_q = to_link(n);
            tail_q = to_link(n);
          end else if (m == MODE_PUSH_BACK) begin
            prev_tab[n] = tail_q;
            next_tab[n] = NO_LINK;
            next_tab[tail_q.idx] = to_link(n);
            tail_q = to_link(n);
          end else begin
            prev_tab[n] = NO_LINK;
            next_tab[n] = head_q;
            prev_tab[head_q.idx] = to_link(n);
            head_q = to_link(n);
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        victim = (m == MODE_POP_FRONT) ? head_q : tail_q;
        if (!victim.ok) begin
          v.status = STATUS_EMPTY;
        end else begin
          v.popped = victim;
          detach(victim.idx);
        end
      end
      MODE_REMOVE: begin
        if (!member[n]) v.status = STATUS_MEMBERSHIP;
        else detach(n);
      end
      default: ;  // inspect and the spare codes leave the list alone
    endcase
    v.head  = head_q;
    v.tail  = tail_q;
    v.count = cnt;
    if (member[n]) begin
      v.prev = prev_tab[n];
      v.next = next_tab[n];
    end else begin
      v.prev = NO_LINK;
      v.next = NO_LINK;
    end
    return v;
  endfunction

  task automatic report(string what);
    $display("%0t ns result %0d: %s", $time, results_seen, what);
    fails++;
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    list_view_t want;
    if (!rst_n) begin
      for (int i = 0; i < POOL; i++) begin
        prev_tab[i] = NO_LINK;
        next_tab[i] = NO_LINK;
        member[i]   = 1'b0;
      end
      head_q = NO_LINK;
      tail_q = NO_LINK;
      cnt    = '0;
      expected_q.delete();
    end else begin
      // compare before predicting: a result never belongs to the item taken
      // at the same edge
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("result with no item waiting");
        end else begin
          want = expected_q.pop_front();
          check_field("status", 9'(out_status), 9'(want.status));
          check_field("popped_node", 9'(out_popped_node), 9'(want.popped.idx));
          check_field("popped_valid", 9'(out_popped_valid), 9'(want.popped.ok));
          check_field("head_node", 9'(out_head_node), 9'(want.head.idx));
          check_field("head_valid", 9'(out_head_valid), 9'(want.head.ok));
          check_field("tail_node", 9'(out_tail_node), 9'(want.tail.idx));
          check_field("tail_valid", 9'(out_tail_valid), 9'(want.tail.ok));
          check_field("count", 9'(out_count), 9'(want.count));
          check_field("node_prev", 9'(out_node_prev), 9'(want.prev.idx));
          check_field("node_prev_valid", 9'(out_node_prev_valid), 9'(want.prev.ok));
          check_field("node_next", 9'(out_node_next), 9'(want.next.idx));
          check_field("node_next_valid", 9'(out_node_next_valid), 9'(want.next.ok));
        end
      end
      if (in_valid && in_ready) expected_q.push_back(apply_item(in_mode, in_node));
    end
    fail_count <= fails;
    awaited    <= expected_q.size();
  end

endmodule

// ===== verif/tb_doubly_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_manager
// Drives the list manager with a directed run of corner cases, two mixed runs
// over a narrow node window, and a sweep that fills all 256 nodes and takes
// part of them off again, under three idling patterns; the checker compares.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import dll_pkg::*;

  localparam int    CYCLE_LIMIT  = 200000;
  localparam int    DRAIN_CYCLES = 20;
  localparam mode_t MODE_SPARE_6 = 3'd6;
  localparam mode_t MODE_SPARE_7 = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  mode_t       in_mode   = MODE_INSPECT;
  node_t       in_node   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  status_t     out_status;
  node_t       out_popped_node;
  logic        out_popped_valid;
  node_t       out_head_node;
  logic        out_head_valid;
  node_t       out_tail_node;
  logic        out_tail_valid;
  count_t      out_count;
  node_t       out_node_prev;
  logic        out_node_prev_valid;
  node_t       out_node_next;
  logic        out_node_next_valid;
  int unsigned fail_count;
  int unsigned awaited;
  int unsigned in_idle_pct  = 36;
  int unsigned out_idle_pct = 57;
  int unsigned cycle_cnt    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  doubly_linked_list_manager dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_node             (in_node),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_popped_node     (out_popped_node),
    .out_popped_valid    (out_popped_valid),
    .out_head_node       (out_head_node),
    .out_head_valid      (out_head_valid),
    .out_tail_node       (out_tail_node),
    .out_tail_valid      (out_tail_valid),
    .out_count           (out_count),
    .out_node_prev       (out_node_prev),
    .out_node_prev_valid (out_node_prev_valid),
    .out_node_next       (out_node_next),
    .out_node_next_valid (out_node_next_valid)
  );

  dll_list_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_node             (in_node),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_popped_node     (out_popped_node),
    .out_popped_valid    (out_popped_valid),
    .out_head_node       (out_head_node),
    .out_head_valid      (out_head_valid),
    .out_tail_node       (out_tail_node),
    .out_tail_valid      (out_tail_valid),
    .out_count           (out_count),
    .out_node_prev       (out_node_prev),
    .out_node_prev_valid (out_node_prev_valid),
    .out_node_next       (out_node_next),
    .out_node_next_valid (out_node_next_valid),
    .fail_count          (fail_count),
    .awaited             (awaited)
  );

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item and hold it until it is taken.
  task automatic send_item(mode_t m, node_t n);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_node  <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic void shuffle_nodes(ref node_t pool[256]);
    node_t       tmp;
    int unsigned j;
    for (int i = 255; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
  endfunction

  task automatic run_directed();
    send_item(MODE_POP_FRONT, 8'd0);
    send_item(MODE_POP_BACK, 8'd255);
    send_item(MODE_REMOVE, 8'd0);
    send_item(MODE_INSPECT, 8'd255);
    send_item(MODE_PUSH_BACK, 8'd0);
    send_item(MODE_PUSH_BACK, 8'd255);
    send_item(MODE_PUSH_FRONT, 8'd128);
    send_item(MODE_PUSH_BACK, 8'd0);
    send_item(MODE_PUSH_FRONT, 8'd255);
    send_item(MODE_INSPECT, 8'd0);
    send_item(MODE_SPARE_6, 8'd128);
    send_item(MODE_SPARE_7, 8'd255);
    send_item(MODE_REMOVE, 8'd0);
    send_item(MODE_REMOVE, 8'd0);
    send_item(MODE_PUSH_FRONT, 8'd170);
    send_item(MODE_PUSH_BACK, 8'd85);
    send_item(MODE_REMOVE, 8'd170);
    send_item(MODE_REMOVE, 8'd85);
    send_item(MODE_POP_FRONT, 8'd0);
    send_item(MODE_POP_BACK, 8'd0);
    send_item(MODE_PUSH_FRONT, 8'd1);
    send_item(MODE_REMOVE, 8'd1);
    send_item(MODE_PUSH_BACK, 8'd7);
    send_item(MODE_POP_FRONT, 8'd7);
    send_item(MODE_POP_BACK, 8'd7);
  endtask

  // Mostly a narrow window of nodes so pushes collide and removes hit members.
  task automatic run_mixed(int unsigned n_items);
    node_t       base;
    node_t       nd;
    mode_t       m;
    int unsigned pick;
    base = node_t'($urandom_range(240));
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 26) m = MODE_PUSH_BACK;
      else if (pick < 52) m = MODE_PUSH_FRONT;
      else if (pick < 64) m = MODE_POP_FRONT;
      else if (pick < 76) m = MODE_POP_BACK;
      else if (pick < 90) m = MODE_REMOVE;
      else if (pick < 97) m = MODE_INSPECT;
      else if (pick < 99) m = MODE_SPARE_6;
      else m = MODE_SPARE_7;
      if ($urandom_range(4) == 0) nd = node_t'($urandom);
      else nd = base + node_t'($urandom_range(15));
      send_item(m, nd);
    end
  endtask

  // Fill every node, then take some off by remove and some by pops.
  task automatic run_fill_sweep();
    node_t order[256];
    for (int i = 0; i < 256; i++) order[i] = node_t'(i);
    shuffle_nodes(order);
    for (int i = 0; i < 256; i++) begin
      send_item($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, order[i]);
      if ($urandom_range(15) == 0) send_item(MODE_PUSH_BACK, order[$urandom_range(i)]);
    end
    send_item(MODE_INSPECT, order[$urandom_range(255)]);
    shuffle_nodes(order);
    for (int i = 0; i < 32; i++) send_item(MODE_REMOVE, order[i]);
    for (int i = 0; i < 32; i++)
      send_item($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, node_t'($urandom));
    send_item(MODE_POP_FRONT, 8'd0);
    send_item(MODE_POP_BACK, 8'd0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_mixed(50);
    in_idle_pct  = 57;
    out_idle_pct = 36;
    run_mixed(50);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_fill_sweep();
    in_valid <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
